FILE: rtl/rsh_pkg.sv
package rsh_pkg;

  localparam int LINE_DEPTH = 2048;
  localparam int COL_W      = $clog2(LINE_DEPTH);
  localparam int ROW_W      = 12;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CH_W       = 8;
  localparam int SUM_W      = CH_W + 2;
  localparam int OUT_COL_W  = 11;
  localparam int EFF_W      = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
  localparam int MIN_DIM    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    pixel_t prev2;
    pixel_t prev;
  } line_pair_t;

  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } colsum_t;

  typedef struct packed {
    logic [COL_W-1:0] center_col;
    logic [ROW_W-1:0] center_row;
    logic             emit;
    logic             last;
  } meta_t;

endpackage

FILE: rtl/rsh_if.sv
interface rsh_in_if;
  logic                     valid;
  logic                     ready;
  logic [rsh_pkg::CH_W-1:0] red_in;
  logic [rsh_pkg::CH_W-1:0] green_in;
  logic [rsh_pkg::CH_W-1:0] blue_in;

  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface rsh_out_if;
  logic                          valid;
  logic                          ready;
  logic [rsh_pkg::CH_W-1:0]      red_out;
  logic [rsh_pkg::CH_W-1:0]      green_out;
  logic [rsh_pkg::CH_W-1:0]      blue_out;
  logic [rsh_pkg::OUT_COL_W-1:0] center_col;
  logic [rsh_pkg::ROW_W-1:0]     center_row;
  logic                          last_of_frame;

  modport source (output valid, red_out, green_out, blue_out, center_col, center_row,
                  last_of_frame, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, center_col, center_row,
                  last_of_frame, output ready);
endinterface

FILE: rtl/rgb_sharpen_3x3_stream_core.sv
// 3x3 Laplacian sharpen over an RGB raster stream. Each channel of an interior pixel becomes
// nine times the center minus its eight neighbors, clamped to 0..255; border pixels produce
// no word. New pixels are accepted while earlier ones are in flight unless the output is
// stalled; a completing pixel passes the input register, a column cell and the output register
// before its result word is valid. The single line store holds the two previous lines side by
// side and does at most one read and one write per cycle. Register 0 sets the line width
// (clamped to 3..2048), register 1 the frame height (at least 3); either write restarts the
// frame. Line store contents are not cleared at reset, and the block is ready right after reset.
module rgb_sharpen_3x3_stream_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rsh_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rsh_pkg::CFG_W-1:0]    cfg_data_i,
  rsh_in_if.sink                       pix_i,
  rsh_out_if.source                    res_o
);
  import rsh_pkg::*;

  logic [CFG_W-1:0] width_q;
  logic [CFG_W-1:0] height_q;
  logic [EFF_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             col_wrap;
  logic             row_wrap;

  logic             adv;
  logic             accept;

  logic             a_valid_q;
  pixel_t           a_pix_q;
  meta_t            a_meta_q;
  meta_t            a_meta_d;
  pixel_t           in_pix;

  line_pair_t       rd_data;
  line_pair_t       wr_data;
  logic             shift;

  logic             w_valid_q;
  meta_t            w_meta_q;

  column_t          new_col;
  column_t          col2, col1, col0;
  colsum_t          sum2, sum1, sum0;

  always_comb begin
    if (EFF_W'(width_q) < EFF_W'(MIN_DIM)) begin
      w_eff = EFF_W'(MIN_DIM);
    end else if (EFF_W'(width_q) > EFF_W'(LINE_DEPTH)) begin
      w_eff = EFF_W'(LINE_DEPTH);
    end else begin
      w_eff = EFF_W'(width_q);
    end
    if (height_q < CFG_W'(MIN_DIM)) begin
      h_eff = ROW_W'(MIN_DIM);
    end else begin
      h_eff = ROW_W'(height_q);
    end
  end

  assign accept   = pix_i.valid && adv;
  assign pix_i.ready = adv;

  assign in_pix.red   = pix_i.red_in;
  assign in_pix.green = pix_i.green_in;
  assign in_pix.blue  = pix_i.blue_in;

  assign col_wrap = (EFF_W'(col_q) + EFF_W'(1)) >= w_eff;
  assign row_wrap = ((ROW_W+1)'(row_q) + (ROW_W+1)'(1)) >= (ROW_W+1)'(h_eff);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_comb begin
    a_meta_d.center_col = col_q - COL_W'(1);
    a_meta_d.center_row = row_q - ROW_W'(1);
    a_meta_d.emit       = (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2));
    a_meta_d.last       = col_wrap && row_wrap;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH: begin
          width_q <= cfg_data_i;
          col_q   <= '0;
          row_q   <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          height_q <= cfg_data_i;
          col_q    <= '0;
          row_q    <= '0;
        end
        default: begin
        end
      endcase
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      w_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= pix_i.valid;
      w_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_pix_q  <= in_pix;
      a_meta_q <= a_meta_d;
    end
    if (shift) begin
      w_meta_q <= a_meta_q;
    end
  end

  assign shift   = adv && a_valid_q;
  assign wr_data = '{prev2: rd_data.prev, prev: a_pix_q};
  assign new_col = '{top: rd_data.prev2, mid: rd_data.prev, bot: a_pix_q};

  rsh_line_buf u_line_buf (
    .clk_i   (clk_i),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rd_data),
    .we_i    (shift),
    .waddr_i (a_meta_q.center_col + COL_W'(1)),
    .wdata_i (wr_data)
  );

  rsh_col_cell u_cell2 (
    .clk_i (clk_i),
    .en_i  (shift),
    .col_i (new_col),
    .col_o (col2),
    .sum_o (sum2)
  );

  rsh_col_cell u_cell1 (
    .clk_i (clk_i),
    .en_i  (shift),
    .col_i (col2),
    .col_o (col1),
    .sum_o (sum1)
  );

  rsh_col_cell u_cell0 (
    .clk_i (clk_i),
    .en_i  (shift),
    .col_i (col1),
    .col_o (col0),
    .sum_o (sum0)
  );

  rsh_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .w_valid_i (w_valid_q && (col0.mid == col0.mid)),
    .w_meta_i  (w_meta_q),
    .center_i  (col1.mid),
    .sum0_i    (sum0),
    .sum1_i    (sum1),
    .sum2_i    (sum2),
    .adv_o     (adv),
    .res_o     (res_o)
  );

endmodule

FILE: rtl/rsh_line_buf.sv
module rsh_line_buf (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic [rsh_pkg::COL_W-1:0] raddr_i,
  output rsh_pkg::line_pair_t      rdata_o,
  input  logic                     we_i,
  input  logic [rsh_pkg::COL_W-1:0] waddr_i,
  input  rsh_pkg::line_pair_t      wdata_i
);
  import rsh_pkg::*;

  line_pair_t mem [LINE_DEPTH];
  line_pair_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/rsh_col_cell.sv
module rsh_col_cell (
  input  logic             clk_i,
  input  logic             en_i,
  input  rsh_pkg::column_t col_i,
  output rsh_pkg::column_t col_o,
  output rsh_pkg::colsum_t sum_o
);
  import rsh_pkg::*;

  column_t col_q;
  colsum_t sum_q;
  colsum_t sum_d;

  always_comb begin
    sum_d.red   = SUM_W'(col_i.top.red)   + SUM_W'(col_i.mid.red)   + SUM_W'(col_i.bot.red);
    sum_d.green = SUM_W'(col_i.top.green) + SUM_W'(col_i.mid.green) + SUM_W'(col_i.bot.green);
    sum_d.blue  = SUM_W'(col_i.top.blue)  + SUM_W'(col_i.mid.blue)  + SUM_W'(col_i.bot.blue);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      col_q <= col_i;
      sum_q <= sum_d;
    end
  end

  assign col_o = col_q;
  assign sum_o = sum_q;

endmodule

FILE: rtl/rsh_out_stage.sv
module rsh_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             w_valid_i,
  input  rsh_pkg::meta_t   w_meta_i,
  input  rsh_pkg::pixel_t  center_i,
  input  rsh_pkg::colsum_t sum0_i,
  input  rsh_pkg::colsum_t sum1_i,
  input  rsh_pkg::colsum_t sum2_i,
  output logic             adv_o,
  rsh_out_if.source        res_o
);
  import rsh_pkg::*;

  function automatic logic [CH_W-1:0] sharpen_ch(input logic [CH_W-1:0]  ctr,
                                                 input logic [SUM_W-1:0] sa,
                                                 input logic [SUM_W-1:0] sb,
                                                 input logic [SUM_W-1:0] sc);
    logic [SUM_W+1:0]        tot;
    logic [SUM_W+1:0]        ten;
    logic signed [SUM_W+2:0] acc;
    logic [CH_W-1:0]         res;
    tot = (SUM_W+2)'(sa) + (SUM_W+2)'(sb) + (SUM_W+2)'(sc);
    ten = (SUM_W+2)'({ctr, 3'b000}) + (SUM_W+2)'({ctr, 1'b0});
    acc = $signed({1'b0, ten}) - $signed({1'b0, tot});
    if (acc < 0) begin
      res = '0;
    end else if (acc > $signed((SUM_W+3)'(255))) begin
      res = '1;
    end else begin
      res = acc[CH_W-1:0];
    end
    return res;
  endfunction

  logic            valid_q;
  logic            valid_d;
  pixel_t          pix_q;
  pixel_t          pix_d;
  logic            adv;

  assign adv     = !valid_q || res_o.ready;
  assign valid_d = w_valid_i && w_meta_i.emit;

  always_comb begin
    pix_d.red   = sharpen_ch(center_i.red,   sum0_i.red,   sum1_i.red,   sum2_i.red);
    pix_d.green = sharpen_ch(center_i.green, sum0_i.green, sum1_i.green, sum2_i.green);
    pix_d.blue  = sharpen_ch(center_i.blue,  sum0_i.blue,  sum1_i.blue,  sum2_i.blue);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_d) begin
      pix_q                <= pix_d;
      res_o.center_col     <= OUT_COL_W'(w_meta_i.center_col);
      res_o.center_row     <= w_meta_i.center_row;
      res_o.last_of_frame  <= w_meta_i.last;
    end
  end

  assign res_o.valid     = valid_q;
  assign res_o.red_out   = pix_q.red;
  assign res_o.green_out = pix_q.green;
  assign res_o.blue_out  = pix_q.blue;
  assign adv_o           = adv;

endmodule

FILE: tb/rgb_sharpen_3x3_stream_core_tb.sv
`timescale 1ns / 100ps

module rgb_sharpen_3x3_stream_core_tb;
  import rsh_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_B = CFG_IDX_W'(3);
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_MAX      = 7;

  typedef struct packed {
    pixel_t               px;
    logic [OUT_COL_W-1:0] col;
    logic [ROW_W-1:0]     row;
    logic                 last;
  } sharp_word_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  rsh_in_if  pix_if ();
  rsh_out_if res_if ();

  rgb_sharpen_3x3_stream_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pix_i       (pix_if),
    .res_o       (res_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [CFG_W-1:0] frame_width  = WIDTH_RESET;
  logic [CFG_W-1:0] frame_height = HEIGHT_RESET;
  pixel_t           line_prev  [LINE_DEPTH];
  pixel_t           line_prev2 [LINE_DEPTH];
  pixel_t           win_px     [6];
  int unsigned      col_pos = 0;
  int unsigned      row_pos = 0;
  sharp_word_t      pending_words [$];
  int               mismatch_count = 0;
  int               src_gap_max = IDLE_MAX;
  int               sink_stall_max = IDLE_MAX;
  int               sink_hold = 0;

  function automatic logic [CH_W-1:0] clamp_byte(int acc);
    if (acc < 0) return '0;
    if (acc > 255) return 8'd255;
    return CH_W'(acc);
  endfunction

  function automatic pixel_t sharpen_window(pixel_t nb [9]);
    pixel_t o;
    int acc_r, acc_g, acc_b;
    acc_r = 0;
    acc_g = 0;
    acc_b = 0;
    for (int k = 0; k < 9; k++) begin
      if (k == 4) begin
        acc_r += 9 * int'(nb[k].red);
        acc_g += 9 * int'(nb[k].green);
        acc_b += 9 * int'(nb[k].blue);
      end else begin
        acc_r -= int'(nb[k].red);
        acc_g -= int'(nb[k].green);
        acc_b -= int'(nb[k].blue);
      end
    end
    o.red   = clamp_byte(acc_r);
    o.green = clamp_byte(acc_g);
    o.blue  = clamp_byte(acc_b);
    return o;
  endfunction

  function automatic void predict_sharpen(pixel_t px);
    int unsigned w, h, c, r;
    pixel_t      up1, up2;
    pixel_t      nb [9];
    sharp_word_t word;
    w = frame_width;
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    h = frame_height;
    if (h < MIN_DIM) h = MIN_DIM;
    c = col_pos % LINE_DEPTH;
    r = row_pos;
    up1 = line_prev[c];
    up2 = line_prev2[c];
    if (r >= 2 && c >= 2) begin
      nb[0] = win_px[0]; nb[1] = win_px[3]; nb[2] = up2;
      nb[3] = win_px[1]; nb[4] = win_px[4]; nb[5] = up1;
      nb[6] = win_px[2]; nb[7] = win_px[5]; nb[8] = px;
      word.px   = sharpen_window(nb);
      word.col  = OUT_COL_W'(c - 1);
      word.row  = ROW_W'(r - 1);
      word.last = (c + 1 == w) && (r + 1 == h);
      pending_words.push_back(word);
    end
    line_prev2[c] = up1;
    line_prev[c]  = px;
    win_px[0] = win_px[3];
    win_px[1] = win_px[4];
    win_px[2] = win_px[5];
    win_px[3] = up2;
    win_px[4] = up1;
    win_px[5] = px;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c & 32'h7FF;
    row_pos = r & 32'hFFF;
  endfunction

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic check_word();
    sharp_word_t want;
    if (pending_words.size() == 0) begin
      $display("%0t: unexpected word, expected none, actual col %0d row %0d", $time,
               res_if.center_col, res_if.center_row);
      mismatch_count++;
    end else begin
      want = pending_words.pop_front();
      compare_field("red_out", 16'(want.px.red), 16'(res_if.red_out));
      compare_field("green_out", 16'(want.px.green), 16'(res_if.green_out));
      compare_field("blue_out", 16'(want.px.blue), 16'(res_if.blue_out));
      compare_field("center_col", 16'(want.col), 16'(res_if.center_col));
      compare_field("center_row", 16'(want.row), 16'(res_if.center_row));
      compare_field("last_of_frame", 16'(want.last), 16'(res_if.last_of_frame));
    end
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        check_word();
        stall_left = $urandom_range(sink_stall_max, 0);
      end
      if (sink_hold > 0) begin
        sink_hold--;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_pixel(input pixel_t px);
    int gap;
    gap = $urandom_range(src_gap_max, 0);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid    <= 1'b1;
    pix_if.red_in   <= px.red;
    pix_if.green_in <= px.green;
    pix_if.blue_in  <= px.blue;
    do @(posedge clk_i); while (!pix_if.ready);
    predict_sharpen(px);
  endtask

  task automatic send_random_pixels(input int count, input bit harsh);
    pixel_t px;
    for (int i = 0; i < count; i++) begin
      if (harsh) begin
        px.red   = $urandom_range(1, 0) ? 8'd255 : 8'd0;
        px.green = $urandom_range(1, 0) ? 8'd255 : 8'd0;
        px.blue  = $urandom_range(1, 0) ? 8'd255 : 8'd0;
      end else begin
        px.red   = CH_W'($urandom_range(255, 0));
        px.green = CH_W'($urandom_range(255, 0));
        px.blue  = CH_W'($urandom_range(255, 0));
      end
      send_pixel(px);
    end
  endtask

  task automatic drain_results();
    pix_if.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH: begin
        frame_width = value;
        col_pos = 0;
        row_pos = 0;
      end
      REG_IMAGE_HEIGHT: begin
        frame_height = value;
        col_pos = 0;
        row_pos = 0;
      end
      default: ;
    endcase
  endtask

  task automatic set_frame(input int w, input int h);
    write_register(REG_IMAGE_WIDTH, CFG_W'(w));
    write_register(REG_IMAGE_HEIGHT, CFG_W'(h));
  endtask

  task automatic send_ring_frame(input pixel_t ctr, input pixel_t ring);
    for (int k = 0; k < 9; k++) send_pixel((k == 4) ? ctr : ring);
  endtask

  task automatic test_reset_defaults();
    send_random_pixels(32, 1'b0);
  endtask

  task automatic test_clamp_extremes();
    set_frame(MIN_DIM, MIN_DIM);
    send_ring_frame('{8'd255, 8'd0, 8'd100}, '{8'd0, 8'd255, 8'd100});
    send_ring_frame('{8'd0, 8'd255, 8'd7}, '{8'd255, 8'd0, 8'd3});
  endtask

  task automatic test_dims_below_min();
    set_frame(1, 0);
    send_random_pixels(18, 1'b0);
    set_frame(2, 2);
    send_random_pixels(9, 1'b1);
  endtask

  task automatic test_ignored_index();
    set_frame(6, 4);
    send_random_pixels(10, 1'b0);
    write_register(REG_RESERVED_A, 12'hFFF);
    write_register(REG_RESERVED_B, 12'h000);
    send_random_pixels(14, 1'b0);
  endtask

  task automatic test_midframe_restart();
    set_frame(5, 5);
    send_random_pixels(13, 1'b0);
    write_register(REG_IMAGE_HEIGHT, CFG_W'(5));
    send_random_pixels(25, 1'b0);
  endtask

  task automatic test_random_frames();
    int sent, w, h, n, pick;
    sent = 0;
    while (sent < 180) begin
      pick = $urandom_range(9, 0);
      w = (pick == 0) ? $urandom_range(2, 0) : $urandom_range(12, 3);
      h = (pick == 1) ? $urandom_range(2, 0) : $urandom_range(6, 3);
      if ($urandom_range(1, 0)) begin
        set_frame(w, h);
      end else begin
        write_register(REG_IMAGE_HEIGHT, CFG_W'(h));
        write_register(REG_IMAGE_WIDTH, CFG_W'(w));
      end
      if (w < MIN_DIM) w = MIN_DIM;
      if (h < MIN_DIM) h = MIN_DIM;
      n = w * h * $urandom_range(2, 1);
      if ($urandom_range(4, 0) == 0) n = $urandom_range(n - 1, 1);
      src_gap_max    = ($urandom_range(3, 0) == 0) ? 0 : IDLE_MAX;
      sink_stall_max = ($urandom_range(3, 0) == 0) ? 0 : IDLE_MAX;
      send_random_pixels(n, $urandom_range(3, 0) == 0);
      sent += n;
    end
    src_gap_max    = IDLE_MAX;
    sink_stall_max = IDLE_MAX;
  endtask

  task automatic test_output_stall();
    set_frame(8, 5);
    src_gap_max = 0;
    sink_hold   = 300;
    send_random_pixels(40, 1'b0);
    drain_results();
    send_random_pixels(40, 1'b0);
    src_gap_max = IDLE_MAX;
  endtask

  task automatic test_widest_line();
    src_gap_max    = 0;
    sink_stall_max = 0;
    set_frame(4095, MIN_DIM);
    send_random_pixels(48, 1'b0);
    src_gap_max    = IDLE_MAX;
    sink_stall_max = IDLE_MAX;
  endtask

  task automatic test_tallest_frame();
    src_gap_max    = 0;
    sink_stall_max = 0;
    set_frame(MIN_DIM, 4095);
    send_random_pixels(MIN_DIM * 12, 1'b0);
    src_gap_max    = IDLE_MAX;
    sink_stall_max = IDLE_MAX;
  endtask

  initial begin
    foreach (line_prev[i]) begin
      line_prev[i]  = '0;
      line_prev2[i] = '0;
    end
    foreach (win_px[i]) win_px[i] = '0;
    pix_if.valid    <= 1'b0;
    pix_if.red_in   <= '0;
    pix_if.green_in <= '0;
    pix_if.blue_in  <= '0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= REG_IMAGE_WIDTH;
    cfg_data_i      <= '0;
    rst_ni          <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_clamp_extremes();
    test_dims_below_min();
    test_ignored_index();
    test_midframe_restart();
    test_random_frames();
    test_output_stall();
    test_widest_line();
    test_tallest_frame();
    drain_results();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: files.f
rtl/rsh_pkg.sv
rtl/rsh_if.sv
rtl/rsh_line_buf.sv
rtl/rsh_col_cell.sv
rtl/rsh_out_stage.sv
rtl/rgb_sharpen_3x3_stream_core.sv
tb/rgb_sharpen_3x3_stream_core_tb.sv
